[design/per_source_sequence_tracker_top_assert.svh]
// Assertion macros for the sequence tracker top level.
// Both expect clk and arst_n in scope.
`ifndef PER_SOURCE_SEQUENCE_TRACKER_TOP_ASSERT_SVH
`define PER_SOURCE_SEQUENCE_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication
`define PSST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PSST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/psst_pkg.sv]
package psst_pkg;

	localparam int SEQ_W  = 32;
	localparam int IP_W   = 32;
	localparam int PORT_W = 16;
	localparam int KEY_W  = IP_W + PORT_W;
	localparam int SLOT_W = 5;

	// packet kind
	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		STATUS_IN_ORDER  = 3'd0,
		STATUS_GAP       = 3'd1,
		STATUS_DUPLICATE = 3'd2,
		STATUS_FULL      = 3'd3,
		STATUS_QUERY     = 3'd4
	} status_t;

endpackage

[design/psst_if.sv]
// Packet header channel
interface psst_pkt_if;
	logic                             valid;
	logic                             ready;
	logic                             cmd;
	logic [psst_pkg::IP_W-1:0]        src_ip;
	logic [psst_pkg::PORT_W-1:0]      src_port;
	logic signed [psst_pkg::SEQ_W-1:0] seq_num;

	modport source (output valid, cmd, src_ip, src_port, seq_num, input ready);
	modport sink (input valid, cmd, src_ip, src_port, seq_num, output ready);
endinterface

// Result channel
interface psst_res_if;
	logic                              valid;
	logic                              ready;
	psst_pkg::status_t                 status;
	logic                              ack_valid;
	logic signed [psst_pkg::SEQ_W-1:0] ack_seq;
	logic [psst_pkg::SLOT_W-1:0]       session_slot;
	logic                              new_session;

	modport source (output valid, status, ack_valid, ack_seq, session_slot, new_session,
		input ready);
	modport sink (input valid, status, ack_valid, ack_seq, session_slot, new_session,
		output ready);
endinterface

[design/psst_table.sv]
// Session table: source key and expected sequence per entry.
// One write and one registered read per cycle.
module psst_table #(
	parameter int ENTRIES = 32,
	parameter int IDX_W   = 5
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [IDX_W-1:0]              rd_addr,
	output logic [psst_pkg::KEY_W-1:0]    rd_key,
	output logic [psst_pkg::SEQ_W-1:0]    rd_exp,
	input  logic                          wr_en,
	input  logic [IDX_W-1:0]              wr_addr,
	input  logic [psst_pkg::KEY_W-1:0]    wr_key,
	input  logic [psst_pkg::SEQ_W-1:0]    wr_exp
);

	logic [psst_pkg::KEY_W-1:0] key_mem [ENTRIES];
	logic [psst_pkg::SEQ_W-1:0] exp_mem [ENTRIES];
	logic [psst_pkg::KEY_W-1:0] rd_key_q;
	logic [psst_pkg::SEQ_W-1:0] rd_exp_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			exp_mem[wr_addr] <= wr_exp;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_exp_q <= exp_mem[rd_addr];
		end
	end

	assign rd_key = rd_key_q;
	assign rd_exp = rd_exp_q;

endmodule

[design/per_source_sequence_tracker_top.sv]
// Per-source sequence tracker. Each accepted header word is looked up by (src_ip, src_port)
// in a session table of SESSION_ENTRIES entries; unknown sources get a new entry with
// expected sequence 1 while room is left. The table is scanned from entry 0 up to the fill
// count, stopping early when the source is found, one entry per cycle through its single
// registered read port, followed by an update state that waits for the output register.
// Only entries below the fill count are read, so no clearing pass follows reset. The next
// header is taken while the previous result still waits in the output register.
`include "per_source_sequence_tracker_top_assert.svh"

module per_source_sequence_tracker_top #(
	parameter int SESSION_ENTRIES = 32
) (
	input logic          clk,
	input logic          arst_n,
	psst_pkt_if.sink     pkt,
	psst_res_if.source   res
);

	localparam int IdxW = (SESSION_ENTRIES > 1) ? $clog2(SESSION_ENTRIES) : 1;
	localparam int CntW = $clog2(SESSION_ENTRIES + 1);
	localparam logic [CntW-1:0] EntriesC = CntW'(SESSION_ENTRIES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t state_q;

	// control
	logic [CntW-1:0] used_q;
	logic [CntW-1:0] iss_q;
	logic            chk_v_s1;
	logic            res_valid_q;

	// header and lookup result
	logic                              cmd_q;
	logic [psst_pkg::IP_W-1:0]         ip_q;
	logic [psst_pkg::PORT_W-1:0]       port_q;
	logic signed [psst_pkg::SEQ_W-1:0] seq_q;
	logic [IdxW-1:0]                   chk_idx_s1;
	logic                              found_q;
	logic [IdxW-1:0]                   slot_q;
	logic signed [psst_pkg::SEQ_W-1:0] exp_q;

	// output word
	psst_pkg::status_t                 status_q;
	logic                              ack_valid_q;
	logic signed [psst_pkg::SEQ_W-1:0] ack_seq_q;
	logic [psst_pkg::SLOT_W-1:0]       slot_out_q;
	logic                              new_q;

	// table ports
	logic                          rd_en;
	logic [IdxW-1:0]               rd_addr;
	logic [psst_pkg::KEY_W-1:0]    rd_key;
	logic [psst_pkg::SEQ_W-1:0]    rd_exp;
	logic                          wr_en;
	logic [IdxW-1:0]               wr_addr;
	logic [psst_pkg::SEQ_W-1:0]    wr_exp;

	logic                              accept;
	logic                              hit;
	logic                              scan_done;
	logic                              load;
	logic                              full;
	logic                              created;
	logic [IdxW-1:0]                   slot;
	logic signed [psst_pkg::SEQ_W-1:0] exp_cur;
	logic                              dup;
	logic                              take;
	psst_pkg::status_t                 status;

	assign accept = pkt.valid && pkt.ready;
	assign pkt.ready = (state_q == ST_IDLE);

	// scan: one read issued per cycle, compare in the cycle after
	assign hit       = chk_v_s1 && (rd_key == {ip_q, port_q});
	assign scan_done = !chk_v_s1 && (iss_q == used_q);
	assign rd_en     = (state_q == ST_SCAN) && (iss_q < used_q) && !hit;
	assign rd_addr   = iss_q[IdxW-1:0];

	// decide on the looked-up entry
	assign full    = !found_q && (used_q == EntriesC);
	assign created = !found_q && !full;
	assign slot    = found_q ? slot_q : used_q[IdxW-1:0];
	assign exp_cur = found_q ? exp_q : psst_pkg::SEQ_W'(1);
	assign dup     = seq_q < exp_cur;
	assign take    = (cmd_q == psst_pkg::CMD_DATA) && !dup;
	assign load    = (state_q == ST_DECIDE) && (!res_valid_q || res.ready);

	always_comb begin
		priority if (full) begin
			status = psst_pkg::STATUS_FULL;
		end else if (cmd_q == psst_pkg::CMD_QUERY) begin
			status = psst_pkg::STATUS_QUERY;
		end else if (dup) begin
			status = psst_pkg::STATUS_DUPLICATE;
		end else if (seq_q == exp_cur) begin
			status = psst_pkg::STATUS_IN_ORDER;
		end else begin
			status = psst_pkg::STATUS_GAP;
		end
	end

	// write back new entry and/or advanced expected number
	assign wr_en   = load && !full && (created || take);
	assign wr_addr = slot;
	assign wr_exp  = take ? psst_pkg::SEQ_W'(seq_q + psst_pkg::SEQ_W'(1))
		: psst_pkg::SEQ_W'(1);

	psst_table #(
		.ENTRIES (SESSION_ENTRIES),
		.IDX_W   (IdxW)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_exp  (rd_exp),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  ({ip_q, port_q}),
		.wr_exp  (wr_exp)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			iss_q       <= '0;
			chk_v_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// result register: loading wins over draining
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						iss_q    <= '0;
						chk_v_s1 <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// rd_en is low on a hit or at the end of the scan
					chk_v_s1 <= rd_en;
					if (rd_en) begin
						iss_q <= iss_q + 1'b1;
					end
					if (hit || scan_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (load) begin
						if (created) begin
							used_q <= used_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= pkt.cmd;
			ip_q   <= pkt.src_ip;
			port_q <= pkt.src_port;
			seq_q  <= pkt.seq_num;
		end
		chk_idx_s1 <= rd_addr;
		if (state_q == ST_SCAN) begin
			if (hit) begin
				found_q <= 1'b1;
				slot_q  <= chk_idx_s1;
				exp_q   <= rd_exp;
			end else if (scan_done) begin
				found_q <= 1'b0;
			end
		end
		if (load) begin
			status_q    <= status;
			ack_valid_q <= (cmd_q == psst_pkg::CMD_DATA);
			ack_seq_q   <= (cmd_q == psst_pkg::CMD_DATA) ? seq_q : '0;
			slot_out_q  <= full ? '0 : psst_pkg::SLOT_W'(slot);
			new_q       <= created;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = status_q;
	assign res.ack_valid    = ack_valid_q;
	assign res.ack_seq      = ack_seq_q;
	assign res.session_slot = slot_out_q;
	assign res.new_session  = new_q;

	// checks
	`PSST_ASSERT_NOW(a_used_bound, 1'b1, used_q <= EntriesC, "fill count beyond table size")
	`PSST_ASSERT_NOW(a_wr_decide, wr_en, state_q == ST_DECIDE, "table write outside update")
	`PSST_ASSERT_NEXT(a_new_count, load && created, used_q == $past(used_q) + 1'b1, "missed new")
	`PSST_ASSERT_NEXT(a_one_item, accept, !pkt.ready, "header taken while busy")

endmodule

[verif/per_source_sequence_tracker_top_tb.sv]
`timescale 1ns / 100ps

module per_source_sequence_tracker_top_tb;
	import psst_pkg::*;

	localparam int TABLE_DEPTH  = 32;
	localparam int RANDOM_WORDS = 1100;
	localparam int PHASE_LEN    = 140;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct {
		logic                    cmd;
		logic [IP_W-1:0]         ip;
		logic [PORT_W-1:0]       port;
		logic signed [SEQ_W-1:0] seq;
	} hdr_word_t;

	typedef struct {
		status_t                 status;
		logic                    ack_valid;
		logic signed [SEQ_W-1:0] ack_seq;
		logic [SLOT_W-1:0]       slot;
		logic                    created;
	} verdict_t;

	logic clk;
	logic arst_n;

	psst_pkt_if pkt_bus ();
	psst_res_if res_bus ();

	per_source_sequence_tracker_top #(
		.SESSION_ENTRIES(TABLE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pkt   (pkt_bus),
		.res   (res_bus)
	);

	// predictor's copy of the session table
	int                      sess_used;
	logic [IP_W-1:0]         sess_ip   [TABLE_DEPTH];
	logic [PORT_W-1:0]       sess_port [TABLE_DEPTH];
	logic signed [SEQ_W-1:0] sess_next [TABLE_DEPTH];

	// stimulus side: known sources and the sequence each is likely to expect
	logic [IP_W-1:0]         src_ip_pool   [$];
	logic [PORT_W-1:0]       src_port_pool [$];
	logic signed [SEQ_W-1:0] src_seq_hint  [$];

	hdr_word_t pending_words_q [$];
	verdict_t  awaited_verdicts_q [$];

	int words_sent;
	int mismatches;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// session lookup, insert and sequence check for one header word
	function automatic verdict_t predict_verdict(logic cmd, logic [IP_W-1:0] ip,
		logic [PORT_W-1:0] port, logic signed [SEQ_W-1:0] seq);
		verdict_t v;
		int       slot;
		logic     known;
		slot        = 0;
		known       = 1'b0;
		v.status    = STATUS_FULL;
		v.ack_valid = 1'b0;
		v.ack_seq   = '0;
		v.slot      = '0;
		v.created   = 1'b0;
		for (int i = 0; i < sess_used; i++) begin
			if (!known && sess_ip[i] == ip && sess_port[i] == port) begin
				known = 1'b1;
				slot  = i;
			end
		end
		if (!known && sess_used < TABLE_DEPTH) begin
			slot            = sess_used;
			sess_ip[slot]   = ip;
			sess_port[slot] = port;
			sess_next[slot] = 32'sd1;
			sess_used++;
			known     = 1'b1;
			v.created = 1'b1;
		end
		// the ack never depends on the session
		if (cmd == CMD_DATA) begin
			v.ack_valid = 1'b1;
			v.ack_seq   = seq;
		end
		if (known) begin
			v.slot = SLOT_W'(slot);
			if (cmd == CMD_QUERY) begin
				v.status = STATUS_QUERY;
			end else if (seq < sess_next[slot]) begin
				v.status = STATUS_DUPLICATE;
			end else begin
				v.status        = (seq == sess_next[slot]) ? STATUS_IN_ORDER : STATUS_GAP;
				sess_next[slot] = seq + 32'sd1;
			end
		end
		return v;
	endfunction

	function automatic int add_source(logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
		src_ip_pool.push_back(ip);
		src_port_pool.push_back(port);
		src_seq_hint.push_back(32'sd1);
		return src_ip_pool.size() - 1;
	endfunction

	function automatic void queue_word(logic cmd, int k, logic signed [SEQ_W-1:0] seq);
		hdr_word_t w;
		w.cmd  = cmd;
		w.ip   = src_ip_pool[k];
		w.port = src_port_pool[k];
		w.seq  = seq;
		pending_words_q.push_back(w);
		if (cmd == CMD_DATA && seq >= src_seq_hint[k])
			src_seq_hint[k] = seq + 32'sd1;
	endfunction

	// idle percentage for the current phase: none, sender, receiver, both
	function automatic int idle_pct(bit rx_side);
		int phase;
		phase = (words_sent / PHASE_LEN) % 4;
		if (phase == 3)
			return 7;
		if (phase == (rx_side ? 2 : 1))
			return 60;
		return 0;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic build_stimulus();
		int                      a, b, c, d, k, n, pick;
		logic [IP_W-1:0]         ip;
		logic [PORT_W-1:0]       port;
		logic signed [SEQ_W-1:0] h, s;
		logic                    cmd;

		// directed: extremes, wrap, duplicates below the start value, partial key match
		a = add_source(32'h0000_0000, 16'h0000);
		queue_word(CMD_QUERY, a, 32'sd0);
		queue_word(CMD_DATA, a, 32'sd1);
		queue_word(CMD_DATA, a, 32'sd1);
		queue_word(CMD_DATA, a, 32'sh7fff_ffff);
		queue_word(CMD_DATA, a, 32'sh8000_0000);
		queue_word(CMD_DATA, a, 32'sh8000_0000);
		b = add_source(32'hffff_ffff, 16'hffff);
		queue_word(CMD_DATA, b, 32'sh8000_0000);
		queue_word(CMD_DATA, b, 32'sd0);
		queue_word(CMD_DATA, b, 32'sd5);
		c = add_source(32'hffff_ffff, 16'h0000);
		queue_word(CMD_DATA, c, 32'sd1);
		d = add_source(32'h0000_0000, 16'hffff);
		queue_word(CMD_QUERY, d, 32'sh7fff_ffff);
		queue_word(CMD_QUERY, a, 32'sd0);
		queue_word(CMD_DATA, d, 32'sd2);
		queue_word(CMD_DATA, d, 32'sd2);
		queue_word(CMD_DATA, c, 32'sd2);

		// random: mostly running sequences on known sources, new sources now and then
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 20 == 0 || $urandom_range(0, 15) == 0) begin
				ip   = $urandom;
				port = PORT_W'($urandom_range(0, 65535));
				pick = $urandom_range(0, 3);
				if (pick == 0)
					ip = src_ip_pool[$urandom_range(0, src_ip_pool.size() - 1)];
				else if (pick == 1)
					port = src_port_pool[$urandom_range(0, src_port_pool.size() - 1)];
				k = add_source(ip, port);
			end else if (src_ip_pool.size() > TABLE_DEPTH && $urandom_range(0, 4) != 0) begin
				k = $urandom_range(0, TABLE_DEPTH - 1);
			end else begin
				k = $urandom_range(0, src_ip_pool.size() - 1);
			end

			cmd  = ($urandom_range(0, 9) == 0) ? CMD_QUERY : CMD_DATA;
			h    = src_seq_hint[k];
			pick = $urandom_range(0, 99);
			if (pick < 45)
				s = h;
			else if (pick < 60)
				s = h + $signed(32'($urandom_range(1, 8)));
			else if (pick < 78)
				s = h - $signed(32'($urandom_range(1, 8)));
			else if (pick < 86)
				s = $urandom;
			else if (pick < 92)
				s = 32'sh7fff_ffff - $signed(32'($urandom_range(0, 2)));
			else if (pick < 96)
				s = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			else
				s = $urandom_range(0, 1) ? 32'sd0 : 32'sd1;
			queue_word(cmd, k, s);
		end
	endtask

	// driver: hold each word until taken, predict it on acceptance
	always @(posedge clk or negedge arst_n) begin
		hdr_word_t w;
		logic      present;
		if (!arst_n) begin
			pkt_bus.valid    <= 1'b0;
			pkt_bus.cmd      <= CMD_DATA;
			pkt_bus.src_ip   <= '0;
			pkt_bus.src_port <= '0;
			pkt_bus.seq_num  <= '0;
		end else begin
			if (pkt_bus.valid && pkt_bus.ready) begin
				awaited_verdicts_q.push_back(predict_verdict(pkt_bus.cmd, pkt_bus.src_ip,
					pkt_bus.src_port, pkt_bus.seq_num));
				words_sent++;
			end
			if (!pkt_bus.valid || pkt_bus.ready) begin
				present = pending_words_q.size() != 0 &&
					!($urandom_range(0, 99) < idle_pct(1'b0));
				if (present) begin
					w = pending_words_q.pop_front();
					pkt_bus.valid    <= 1'b1;
					pkt_bus.cmd      <= w.cmd;
					pkt_bus.src_ip   <= w.ip;
					pkt_bus.src_port <= w.port;
					pkt_bus.seq_num  <= w.seq;
				end else begin
					pkt_bus.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		verdict_t v;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (awaited_verdicts_q.size() == 0) begin
					report_mismatch("result word with no header pending");
				end else begin
					v = awaited_verdicts_q.pop_front();
					if (res_bus.status !== v.status)
						report_mismatch($sformatf("status %0d, want %0d",
							res_bus.status, v.status));
					if (res_bus.ack_valid !== v.ack_valid)
						report_mismatch($sformatf("ack_valid %b, want %b",
							res_bus.ack_valid, v.ack_valid));
					if (res_bus.ack_seq !== v.ack_seq)
						report_mismatch($sformatf("ack_seq %0d, want %0d",
							res_bus.ack_seq, v.ack_seq));
					if (res_bus.session_slot !== v.slot)
						report_mismatch($sformatf("session_slot %0d, want %0d",
							res_bus.session_slot, v.slot));
					if (res_bus.new_session !== v.created)
						report_mismatch($sformatf("new_session %b, want %b",
							res_bus.new_session, v.created));
				end
			end
			res_bus.ready <= !($urandom_range(0, 99) < idle_pct(1'b1));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("per_source_sequence_tracker_top_tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		pkt_bus.valid    = 1'b0;
		pkt_bus.cmd      = CMD_DATA;
		pkt_bus.src_ip   = '0;
		pkt_bus.src_port = '0;
		pkt_bus.seq_num  = '0;
		res_bus.ready    = 1'b0;
		sess_used        = 0;
		words_sent       = 0;
		mismatches       = 0;
		cycles           = 0;
		build_stimulus();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: everything sent and answered, then let stragglers show up
		while (pending_words_q.size() != 0 || pkt_bus.valid || awaited_verdicts_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("per_source_sequence_tracker_top_tb: PASS");
		else
			$display("per_source_sequence_tracker_top_tb: FAIL");
		$finish;
	end

endmodule
